// File: rtl/maexp_pkg.sv
// maexp_pkg: shared types and constants for the modular ALU.
// No dependencies.
`timescale 1ns / 1ps
package maexp_pkg;

  localparam int unsigned QW = 31;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_POW = 3'd3,
    FUNC_INV = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_INV0   = 2'd1,
    ERR_NEGEXP = 2'd2
  } err_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,    // latch operands, start reductions
    OP_SETUP,   // pick exponent, init accumulator
    OP_ADDSUB,  // final add/sub result
    OP_MULRA,   // start multiply ra*rb
    OP_MULACC,  // start acc*base
    OP_MULSQ    // start base*base
  } dop_t;

  typedef struct packed {
    dop_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;   // operand reduction finished
    logic mul_done;   // multiply-reduce finished
    logic degenerate; // modulus below 2
    logic b_neg;
    logic ra_zero;
    logic exp_zero;
    logic exp_lsb;
  } dp_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_DISPATCH, ST_MUL_WAIT, ST_POW_TEST, ST_ACC_WAIT,
    ST_SQ_WAIT, ST_DONE
  } state_t;

endpackage

// File: rtl/modular_alu_with_exponentiation_core.sv
// modular_alu_with_exponentiation_core: top level of the modular ALU.
// Uses maexp_pkg, maexp_ctrl, maexp_datapath.
`timescale 1ns / 1ps
// Modular ALU over a programmable modulus (APB register 0, reset 12289).
// One transaction in gives one transaction out. Items are processed one at
// a time. Both operands are reduced by bit-serial dividers; each modular
// multiply runs on one shared multiplier and 64-step remainder unit. Power
// does a square for every exponent bit and one more multiply for every one
// bit; inverse is power with exponent modulus-2. The result sits in an
// output register; a new item is taken as soon as the result has moved into
// it. Error codes: 1 inverse of zero, 2 negative exponent.
module modular_alu_with_exponentiation_core #(
  parameter int unsigned OPERAND_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               func,
  input  logic [OPERAND_WIDTH-1:0] operand_a,
  input  logic [OPERAND_WIDTH-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [30:0]              result,
  output logic [1:0]               error_code
);
  logic [30:0]        modulus;
  logic               in_go, busy, finish, res_zero, out_free;
  maexp_pkg::dp_cmd_t cmd;
  maexp_pkg::dp_sts_t sts;
  maexp_pkg::err_t    err;
  logic [30:0]        acc;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {1'b0, modulus} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) modulus <= 31'd12289;
    else if (psel && penable && pwrite && paddr == 2'd0) modulus <= pwdata[30:0];
  end

  assign in_stall = busy;
  assign in_go    = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  maexp_ctrl u_ctrl (
    .clk, .rst, .in_go, .func, .sts, .out_free, .cmd, .busy, .finish,
    .res_zero, .err
  );

  maexp_datapath #(.OW(OPERAND_WIDTH)) u_dp (
    .clk, .rst, .cmd, .func, .operand_a, .operand_b, .modulus, .sts,
    .acc_out(acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (finish) begin
      result     <= res_zero ? 31'd0 : acc;
      error_code <= err;
    end
  end

`ifndef ASSERT_OFF
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    finish |-> out_free) else $error("result overwritten");
  a_ra_range: assert property (@(posedge clk) disable iff (rst)
    finish && !res_zero |-> (acc < modulus) || (acc == 31'd1))
    else $error("result out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("accept while busy");
`endif
endmodule

// File: rtl/maexp_moddiv.sv
// maexp_moddiv: bit-serial remainder of an unsigned value by a 31-bit modulus.
// Uses maexp_pkg.
`timescale 1ns / 1ps
module maexp_moddiv #(
  parameter int unsigned NW = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NW-1:0]           num,
  input  logic [maexp_pkg::QW-1:0] q,
  output logic                    done,
  output logic [maexp_pkg::QW-1:0] rem
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]           sh;
  logic [maexp_pkg::QW:0]  r;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic [maexp_pkg::QW+1:0] trial;

  assign trial = {r, sh[NW-1]};
  assign rem   = r[maexp_pkg::QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        sh   <= num;
        r    <= '0;
      end else if (busy) begin
        // restoring step, one quotient bit per cycle
        if (trial >= {2'b00, q})
          r <= (maexp_pkg::QW+1)'(trial - {2'b00, q});
        else
          r <= trial[maexp_pkg::QW:0];
        sh  <= {sh[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/maexp_datapath.sv
// maexp_datapath: operand registers, reducers, multiplier and accumulator.
// Uses maexp_pkg and maexp_moddiv.
`timescale 1ns / 1ps
module maexp_datapath #(
  parameter int unsigned OW = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  maexp_pkg::dp_cmd_t       cmd,
  input  logic [2:0]               func,
  input  logic [OW-1:0]            operand_a,
  input  logic [OW-1:0]            operand_b,
  input  logic [maexp_pkg::QW-1:0] modulus,
  output maexp_pkg::dp_sts_t       sts,
  output logic [maexp_pkg::QW-1:0] acc_out
);
  localparam int unsigned QW = maexp_pkg::QW;

  logic [QW-1:0] q;
  logic [OW-1:0] a, b, ea;
  logic [2:0]    fn;
  logic [QW-1:0] ra, rb, acc, base;
  logic [OW-1:0] expo;
  logic          red_pend_a, red_pend_b;
  logic [QW-1:0] rem_a, rem_b, rem_m;
  logic          done_a, done_b, done_m, red_start;
  logic [OW-1:0] mag_a, mag_b;
  logic [QW-1:0] ra_n, rb_n;
  logic          mul_start;
  logic [63:0]   prod;
  logic [QW-1:0] mx, my;
  logic [QW:0]   sum;
  logic [1:0]    mul_dst;

  // reducers sample the magnitude at load, straight from the input ports
  assign mag_a = operand_a[OW-1] ? OW'(~operand_a + 1'b1) : operand_a;
  assign mag_b = operand_b[OW-1] ? OW'(~operand_b + 1'b1) : operand_b;

  maexp_moddiv #(.NW(OW)) u_red_a (
    .clk, .rst, .start(red_start), .num(mag_a), .q, .done(done_a), .rem(rem_a)
  );
  maexp_moddiv #(.NW(OW)) u_red_b (
    .clk, .rst, .start(red_start), .num(mag_b), .q, .done(done_b), .rem(rem_b)
  );
  maexp_moddiv #(.NW(64)) u_red_m (
    .clk, .rst, .start(mul_start), .num(prod), .q, .done(done_m), .rem(rem_m)
  );

  assign ra_n = (a[OW-1] && rem_a != '0) ? QW'(q - rem_a) : rem_a;
  assign rb_n = (b[OW-1] && rem_b != '0) ? QW'(q - rem_b) : rem_b;
  assign sum  = (fn == maexp_pkg::FUNC_SUB) ? ({1'b0, ra} + {1'b0, q} - {1'b0, rb})
                                            : ({1'b0, ra} + {1'b0, rb});

  always_comb begin
    mx = ra;
    my = rb;
    case (cmd.op)
      maexp_pkg::OP_MULACC: begin mx = acc;  my = base; end
      maexp_pkg::OP_MULSQ:  begin mx = base; my = base; end
      default: ;
    endcase
  end

  assign red_start = (cmd.op == maexp_pkg::OP_LOAD);
  assign mul_start = (cmd.op == maexp_pkg::OP_MULRA) || (cmd.op == maexp_pkg::OP_MULACC)
                  || (cmd.op == maexp_pkg::OP_MULSQ);
  assign ea = OW'({1'b0, q} - 32'd2);

  // registering the product ahead of the reducer start is avoided by
  // driving the reducer from the combinational product captured at start
  always_comb prod = {33'd0, mx} * {33'd0, my};

  always_ff @(posedge clk) begin
    if (rst) begin
      red_pend_a <= 1'b0;
      red_pend_b <= 1'b0;
    end else begin
      if (red_start) begin
        red_pend_a <= 1'b1;
        red_pend_b <= 1'b1;
      end else begin
        if (done_a) red_pend_a <= 1'b0;
        if (done_b) red_pend_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      maexp_pkg::OP_LOAD: begin
        a  <= operand_a;
        b  <= operand_b;
        fn <= func;
        q  <= modulus;
      end
      maexp_pkg::OP_SETUP: begin
        acc  <= QW'(1);
        base <= ra;
        expo <= (fn == maexp_pkg::FUNC_INV) ? ea : b;
      end
      maexp_pkg::OP_ADDSUB:
        acc <= (sum >= {1'b0, q}) ? QW'(sum - {1'b0, q}) : sum[QW-1:0];
      default: ;
    endcase
    if (done_a) ra <= ra_n;
    if (done_b) rb <= rb_n;
    // the controller tells which register takes the product
    if (done_m && mul_dst == 2'd0) acc <= rem_m;
    if (done_m && mul_dst == 2'd1) acc <= rem_m;
    if (done_m && mul_dst == 2'd2) begin
      base <= rem_m;
      expo <= expo >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start)
      mul_dst <= (cmd.op == maexp_pkg::OP_MULSQ) ? 2'd2 : 2'd0;
  end

  assign sts.red_done   = !red_pend_a && !red_pend_b;
  assign sts.mul_done   = done_m;
  assign sts.degenerate = (q < QW'(2));
  assign sts.b_neg      = b[OW-1];
  assign sts.ra_zero    = (ra == '0);
  assign sts.exp_zero   = (expo == '0);
  assign sts.exp_lsb    = expo[0];
  assign acc_out        = acc;
endmodule

// File: rtl/maexp_ctrl.sv
// maexp_ctrl: sequencer for the modular ALU.
// Uses maexp_pkg.
`timescale 1ns / 1ps
module maexp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_go,
  input  logic [2:0]         func,
  input  maexp_pkg::dp_sts_t sts,
  input  logic               out_free,
  output maexp_pkg::dp_cmd_t cmd,
  output logic               busy,
  output logic               finish,
  output logic               res_zero,
  output maexp_pkg::err_t    err
);
  maexp_pkg::state_t state, state_next;
  logic [2:0]        fn;
  maexp_pkg::err_t   err_next;
  logic              zero_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= maexp_pkg::ST_IDLE;
      err      <= maexp_pkg::ERR_OK;
      res_zero <= 1'b0;
    end else begin
      state    <= state_next;
      err      <= err_next;
      res_zero <= zero_next;
    end
    if (in_go) fn <= func;
  end

  always_comb begin
    state_next = state;
    cmd.op     = maexp_pkg::OP_NONE;
    err_next   = err;
    zero_next  = res_zero;
    finish     = 1'b0;
    case (state)
      maexp_pkg::ST_IDLE: begin
        if (in_go) begin
          cmd.op     = maexp_pkg::OP_LOAD;
          err_next   = maexp_pkg::ERR_OK;
          zero_next  = 1'b0;
          state_next = maexp_pkg::ST_RED;
        end
      end
      maexp_pkg::ST_RED:
        if (sts.red_done) state_next = maexp_pkg::ST_DISPATCH;
      maexp_pkg::ST_DISPATCH: begin
        state_next = maexp_pkg::ST_DONE;
        if (sts.degenerate) zero_next = 1'b1;
        else begin
          case (fn)
            maexp_pkg::FUNC_ADD, maexp_pkg::FUNC_SUB: cmd.op = maexp_pkg::OP_ADDSUB;
            maexp_pkg::FUNC_MUL: begin
              cmd.op     = maexp_pkg::OP_MULRA;
              state_next = maexp_pkg::ST_MUL_WAIT;
            end
            maexp_pkg::FUNC_POW: begin
              if (sts.b_neg) begin
                zero_next = 1'b1;
                err_next  = maexp_pkg::ERR_NEGEXP;
              end else begin
                cmd.op     = maexp_pkg::OP_SETUP;
                state_next = maexp_pkg::ST_POW_TEST;
              end
            end
            maexp_pkg::FUNC_INV: begin
              if (sts.ra_zero) begin
                zero_next = 1'b1;
                err_next  = maexp_pkg::ERR_INV0;
              end else begin
                cmd.op     = maexp_pkg::OP_SETUP;
                state_next = maexp_pkg::ST_POW_TEST;
              end
            end
            default: zero_next = 1'b1;
          endcase
        end
      end
      maexp_pkg::ST_MUL_WAIT:
        if (sts.mul_done) state_next = maexp_pkg::ST_DONE;
      maexp_pkg::ST_POW_TEST: begin
        if (sts.exp_zero) state_next = maexp_pkg::ST_DONE;
        else if (sts.exp_lsb) begin
          cmd.op     = maexp_pkg::OP_MULACC;
          state_next = maexp_pkg::ST_ACC_WAIT;
        end else begin
          cmd.op     = maexp_pkg::OP_MULSQ;
          state_next = maexp_pkg::ST_SQ_WAIT;
        end
      end
      maexp_pkg::ST_ACC_WAIT:
        if (sts.mul_done) begin
          cmd.op     = maexp_pkg::OP_MULSQ;
          state_next = maexp_pkg::ST_SQ_WAIT;
        end
      maexp_pkg::ST_SQ_WAIT:
        if (sts.mul_done) state_next = maexp_pkg::ST_POW_TEST;
      maexp_pkg::ST_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = maexp_pkg::ST_IDLE;
        end
      end
      default: state_next = maexp_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != maexp_pkg::ST_IDLE);

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == maexp_pkg::OP_LOAD |-> !busy) else $error("load while busy");
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    finish |=> state == maexp_pkg::ST_IDLE) else $error("finish not followed by idle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    err != maexp_pkg::ERR_OK |-> res_zero) else $error("error without zero result");
`endif
endmodule
